>>> sv/spa_pkg.sv
// shared types and constants for the sparse polynomial add unit
// no dependencies

package spa_pkg;

   localparam int TERMS_PER_POLY = 32;
   localparam int ADDR_W = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;
   localparam int CNT_W = $clog2(TERMS_PER_POLY + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QADDR_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] CMD_LOAD_A = 2'd0;
   localparam logic [1:0] CMD_LOAD_B = 2'd1;
   localparam logic [1:0] CMD_MERGE = 2'd2;

   typedef struct packed {
      logic [1:0] command;
      logic signed [15:0] coefficient;
      logic [15:0] exponent;
   } req_word_type;

   typedef struct packed {
      logic signed [16:0] sum_coefficient;
      logic [15:0] sum_exponent;
      logic last_term;
      logic empty_result;
      logic overflow_seen;
   } rsp_word_type;

   typedef struct packed {
      logic merge;
      logic to_b;
      logic signed [15:0] coefficient;
      logic [15:0] exponent;
   } queue_entry_type;

   typedef struct packed {
      logic valid;
      queue_entry_type entry;
   } queue_head_type;

endpackage

>>> sv/sparse_polynomial_add_unit.sv
// sparse polynomial add unit: command queue front end and merge back end
// depends on spa_pkg, spa_front, spa_back
// a taken word waits in the queue until the back end pops it while idle; a load then writes its term store
// a merge of na and nb terms runs one merge step per cycle, then a closing step emits the last term
// results arrive at most one per cycle, the last (marked last_term) after the final merge step
// reset clears the queue, term counts and overflow flag; store contents are not cleared

module sparse_polynomial_add_unit (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  spa_pkg::req_word_type req_word,
   output logic busy,
   output logic rsp_strobe,
   output spa_pkg::rsp_word_type rsp_word
);

   spa_pkg::queue_head_type head;
   logic pop;

   spa_front u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_word(req_word),
      .pop(pop),
      .busy(busy),
      .head(head)
   );

   spa_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .pop(pop),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word)
   );

endmodule

>>> sv/spa_front.sv
// front end: accepts command words, drops unused codes, queues the rest
// depends on spa_pkg

module spa_front (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  spa_pkg::req_word_type req_word,
   input  logic pop,
   output logic busy,
   output spa_pkg::queue_head_type head
);

   spa_pkg::queue_entry_type q_mem_ff [spa_pkg::QUEUE_DEPTH];
   logic [spa_pkg::QADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [spa_pkg::QADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [spa_pkg::QADDR_W:0] fill_ff, fill_in;
   logic accept, push, pop_ok, known_cmd;
   spa_pkg::queue_entry_type new_entry;

   assign busy = (fill_ff == (spa_pkg::QADDR_W + 1)'(spa_pkg::QUEUE_DEPTH));
   assign accept = start && !busy;
   assign known_cmd = (req_word.command == spa_pkg::CMD_LOAD_A) ||
                      (req_word.command == spa_pkg::CMD_LOAD_B) ||
                      (req_word.command == spa_pkg::CMD_MERGE);
   assign push = accept && known_cmd;
   assign pop_ok = pop && (fill_ff != '0);

   assign new_entry.merge = (req_word.command == spa_pkg::CMD_MERGE);
   assign new_entry.to_b = (req_word.command == spa_pkg::CMD_LOAD_B);
   assign new_entry.coefficient = req_word.coefficient;
   assign new_entry.exponent = req_word.exponent;

   assign head.valid = (fill_ff != '0);
   assign head.entry = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop_ok) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_ok && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

>>> sv/spa_back.sv
// back end: term stores, load handling and the sorted merge engine
// depends on spa_pkg

module spa_back (
   input  logic clock,
   input  logic reset,
   input  spa_pkg::queue_head_type head,
   output logic pop,
   output logic rsp_strobe,
   output spa_pkg::rsp_word_type rsp_word
);

   typedef enum logic {ST_IDLE, ST_MERGE} state_type;

   localparam int CW = spa_pkg::CNT_W;
   localparam int AW = spa_pkg::ADDR_W;

   logic [31:0] mem_a [spa_pkg::TERMS_PER_POLY];
   logic [31:0] mem_b [spa_pkg::TERMS_PER_POLY];

   state_type state_ff, state_in;
   logic [CW-1:0] count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [CW-1:0] ia_ff, ia_in, ib_ff, ib_in;
   logic overflow_ff, overflow_in;
   logic [31:0] head_a_ff, head_b_ff;
   logic pend_valid_ff, pend_valid_in;
   logic signed [16:0] pend_coef_ff, pend_coef_in;
   logic [15:0] pend_exp_ff, pend_exp_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   spa_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic wr_a, wr_b;
   logic a_left, b_left, take_a, take_b, keep;
   logic [15:0] exp_a, exp_b, term_exp;
   logic signed [16:0] coef_a, coef_b, term_coef;
   logic [31:0] wr_data;

   assign exp_a = head_a_ff[15:0];
   assign exp_b = head_b_ff[15:0];
   assign coef_a = {head_a_ff[31], head_a_ff[31:16]};
   assign coef_b = {head_b_ff[31], head_b_ff[31:16]};
   assign a_left = (ia_ff < count_a_ff);
   assign b_left = (ib_ff < count_b_ff);
   assign wr_data = {head.entry.coefficient, head.entry.exponent};

   // head selection
   always_comb begin
      take_a = 1'b0;
      take_b = 1'b0;
      priority if (a_left && b_left) begin
         take_a = (exp_a >= exp_b);
         take_b = (exp_b >= exp_a);
      end else if (a_left) begin
         take_a = 1'b1;
      end else begin
         take_b = b_left;
      end
      term_coef = (take_a ? coef_a : 17'sd0) + (take_b ? coef_b : 17'sd0);
      term_exp = take_a ? exp_a : exp_b;
      keep = !(take_a && take_b) || (term_coef != 17'sd0);
   end

   always_comb begin
      state_in = state_ff;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      ia_in = ia_ff;
      ib_in = ib_ff;
      overflow_in = overflow_ff;
      pend_valid_in = pend_valid_ff;
      pend_coef_in = pend_coef_ff;
      pend_exp_in = pend_exp_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in = rsp_word_ff;
      pop = 1'b0;
      wr_a = 1'b0;
      wr_b = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ia_in = '0;
            ib_in = '0;
            if (head.valid) begin
               pop = 1'b1;
               priority if (head.entry.merge) begin
                  state_in = ST_MERGE;
                  pend_valid_in = 1'b0;
               end else if (head.entry.to_b) begin
                  if (count_b_ff == CW'(spa_pkg::TERMS_PER_POLY)) begin
                     overflow_in = 1'b1;
                  end else begin
                     wr_b = 1'b1;
                     count_b_in = count_b_ff + CW'(1);
                  end
               end else begin
                  if (count_a_ff == CW'(spa_pkg::TERMS_PER_POLY)) begin
                     overflow_in = 1'b1;
                  end else begin
                     wr_a = 1'b1;
                     count_a_in = count_a_ff + CW'(1);
                  end
               end
            end
         end
         ST_MERGE: begin
            if (a_left || b_left) begin
               ia_in = ia_ff + CW'(take_a);
               ib_in = ib_ff + CW'(take_b);
               if (keep) begin
                  if (pend_valid_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_word_in.sum_coefficient = pend_coef_ff;
                     rsp_word_in.sum_exponent = pend_exp_ff;
                     rsp_word_in.last_term = 1'b0;
                     rsp_word_in.empty_result = 1'b0;
                     rsp_word_in.overflow_seen = overflow_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_coef_in = term_coef;
                  pend_exp_in = term_exp;
               end
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_word_in.sum_coefficient = pend_valid_ff ? pend_coef_ff : 17'sd0;
               rsp_word_in.sum_exponent = pend_valid_ff ? pend_exp_ff : 16'd0;
               rsp_word_in.last_term = 1'b1;
               rsp_word_in.empty_result = !pend_valid_ff;
               rsp_word_in.overflow_seen = overflow_ff;
               count_a_in = '0;
               count_b_in = '0;
               overflow_in = 1'b0;
               pend_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // term stores, registered read at the next head index
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[count_a_ff[AW-1:0]] <= wr_data;
      end
      head_a_ff <= mem_a[ia_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[count_b_ff[AW-1:0]] <= wr_data;
      end
      head_b_ff <= mem_b[ib_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_a_ff <= '0;
         count_b_ff <= '0;
         ia_ff <= '0;
         ib_ff <= '0;
         overflow_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         ia_ff <= ia_in;
         ib_ff <= ib_in;
         overflow_ff <= overflow_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      pend_coef_ff <= pend_coef_in;
      pend_exp_ff <= pend_exp_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word = rsp_word_ff;

endmodule

>>> sv/spa_checker.sv
// port-level checks for the sparse polynomial add unit, bound to the top level
// depends on spa_pkg and sparse_polynomial_add_unit

module spa_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_strobe,
   input spa_pkg::rsp_word_type rsp_word
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe && !busy)
      else $error("result strobe or busy after reset");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.empty_result |-> rsp_word.last_term)
      else $error("empty result not marked last");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.empty_result |->
         (rsp_word.sum_coefficient == 17'sd0) && (rsp_word.sum_exponent == 16'd0))
      else $error("empty result carries a term");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.last_term |=> !rsp_strobe)
      else $error("result right after last term");

endmodule

bind sparse_polynomial_add_unit spa_checker u_spa_checker (.*);
